// File: sv/cyclic_competition_lattice_step_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lattice step block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_COMPETITION_LATTICE_STEP_TOP_ASSERT_SVH
`define CYCLIC_COMPETITION_LATTICE_STEP_TOP_ASSERT_SVH

// Same-cycle implication.
`define CCLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ccls_pkg.sv
// ----------------------------------------------------------------------------
// ccls_pkg
// Widths, codes and shared types of the cyclic competition lattice block.
// ----------------------------------------------------------------------------
package ccls_pkg;

  localparam int SIDE_DEF = 128;

  localparam int MODE_W  = 2;
  localparam int COORD_W = 7;
  localparam int SP_W    = 2;
  localparam int DIR_W   = 2;
  localparam int FRAC_W  = 16;
  localparam int RATE_W  = 17;
  localparam int CNT_W   = 15;
  // current grid word: written flag on top of the species code
  localparam int CUR_W   = SP_W + 1;
  localparam int WR_BIT  = SP_W;

  localparam logic [RATE_W-1:0] RATE_RESET = 17'h10000;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd2;

  localparam logic [DIR_W-1:0] DIR_COL_UP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ROW_UP = 2'd1;
  localparam logic [DIR_W-1:0] DIR_COL_DN = 2'd2;
  localparam logic [DIR_W-1:0] DIR_ROW_DN = 2'd3;

  // neighbour species minus chosen species, modulo four
  localparam logic [SP_W-1:0] REL_SAME    = 2'd0;
  localparam logic [SP_W-1:0] REL_PREY    = 2'd1;
  localparam logic [SP_W-1:0] REL_NEUTRAL = 2'd2;
  localparam logic [SP_W-1:0] REL_PRED    = 2'd3;

  typedef struct packed {
    logic             cur_we;
    logic             ini_we;
    logic [CUR_W-1:0] cur_data;
    logic [SP_W-1:0]  ini_data;
  } grid_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [CNT_W-1:0] count_c;
    logic [CNT_W-1:0] count_d;
    logic [CNT_W-1:0] match_ac;
    logic [CNT_W-1:0] initial_ac;
    logic [CNT_W-1:0] now_ac;
    logic [CNT_W-1:0] match_bd;
    logic [CNT_W-1:0] initial_bd;
    logic [CNT_W-1:0] now_bd;
  } result_t;

endpackage

// File: sv/ccls_if.sv
// ----------------------------------------------------------------------------
// ccls channel interfaces
// Valid/ready channels for configuration, input items and result items.
// ----------------------------------------------------------------------------
interface ccls_cfg_if;
  import ccls_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] switch_rate;
  modport source (output valid, output switch_rate, input ready);
  modport sink (input valid, input switch_rate, output ready);
endinterface

interface ccls_in_if;
  import ccls_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [SP_W-1:0]    species;
  logic [DIR_W-1:0]   direction;
  logic [FRAC_W-1:0]  rand_frac;
  modport source (output valid, output mode, output col, output row, output species,
                  output direction, output rand_frac, input ready);
  modport sink (input valid, input mode, input col, input row, input species,
                input direction, input rand_frac, output ready);
endinterface

interface ccls_out_if;
  import ccls_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] count_c;
  logic [CNT_W-1:0] count_d;
  logic [CNT_W-1:0] match_ac;
  logic [CNT_W-1:0] initial_ac;
  logic [CNT_W-1:0] now_ac;
  logic [CNT_W-1:0] match_bd;
  logic [CNT_W-1:0] initial_bd;
  logic [CNT_W-1:0] now_bd;
  modport source (output valid, output count_a, output count_b, output count_c,
                  output count_d, output match_ac, output initial_ac, output now_ac,
                  output match_bd, output initial_bd, output now_bd, input ready);
  modport sink (input valid, input count_a, input count_b, input count_c,
                input count_d, input match_ac, input initial_ac, input now_ac,
                input match_bd, input initial_bd, input now_bd, output ready);
endinterface

// File: sv/ccls_grid.sv
// ----------------------------------------------------------------------------
// ccls_grid
// Current and initial grid memories, one write and one read port each,
// registered read data.
// ----------------------------------------------------------------------------
module ccls_grid #(
  parameter int SIDE = ccls_pkg::SIDE_DEF,
  localparam int AW  = $clog2(SIDE * SIDE)
) (
  input  logic                       clk_i,
  input  logic [AW-1:0]              rd_addr_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  ccls_pkg::grid_wr_t         wr_i,
  output logic [ccls_pkg::CUR_W-1:0] rd_cur_o,
  output logic [ccls_pkg::SP_W-1:0]  rd_ini_o
);
  import ccls_pkg::*;

  localparam int DEPTH = SIDE * SIDE;

  logic [CUR_W-1:0] cur_mem [DEPTH];
  logic [SP_W-1:0]  ini_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.cur_we) begin
      cur_mem[wr_addr_i] <= wr_i.cur_data;
    end
    rd_cur_o <= cur_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ini_we) begin
      ini_mem[wr_addr_i] <= wr_i.ini_data;
    end
    rd_ini_o <= ini_mem[rd_addr_i];
  end

endmodule

// File: sv/cyclic_competition_lattice_step_top.sv
// ----------------------------------------------------------------------------
// cyclic_competition_lattice_step_top
// Four-species cyclic competition on a toroidal SIDE x SIDE grid: load sites,
// play one neighbour interaction, or sweep the grid for pair correlations.
// ----------------------------------------------------------------------------
//
//  channel | dir | modport | payload
//  --------+-----+---------+-------------------------------------------------
//  cfg_i   | in  | sink    | switch_rate (17 b)
//  in_i    | in  | sink    | mode, col, row, species, direction, rand_frac
//  out_o   | out | source  | count_a..count_d, match/initial/now for ac, bd
//
//  An item is decoded; a load then reads its site, stores it while uncounting
//  the old species and counts the new one; a step reads the site, then its
//  neighbour, evaluates and updates in two states; a measure reads every site
//  in turn; an out-of-range or unused mode goes to finish. A clearing pass
//  after reset marks every site unwritten; in_i.ready stays low meanwhile,
//  cfg_i is taken at any time. A finished result waits in an output register;
//  a new item is accepted while it waits, and the next result holds in the
//  finish state until out_o drains.
`include "cyclic_competition_lattice_step_top_assert.svh"

module cyclic_competition_lattice_step_top #(
  parameter int SIDE = ccls_pkg::SIDE_DEF,
  localparam int AW  = $clog2(SIDE * SIDE)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccls_cfg_if.sink  cfg_i,
  ccls_in_if.sink   in_i,
  ccls_out_if.source out_o
);
  import ccls_pkg::*;

  localparam int SITES = SIDE * SIDE;
  localparam int CW    = $clog2(SIDE);
  // wide enough to hold both a raw coordinate and SIDE itself
  localparam int XW    = ($clog2(SIDE + 1) > COORD_W) ? $clog2(SIDE + 1) : COORD_W;

  localparam logic [AW-1:0]    LAST_ADDR = AW'(SITES - 1);
  localparam logic [AW-1:0]    SIDE_A    = AW'(SIDE);
  localparam logic [CW-1:0]    SIDE_M1   = CW'(SIDE - 1);
  localparam logic [CW-1:0]    CRD_ONE   = CW'(1);
  localparam logic [XW-1:0]    SIDE_X    = XW'(SIDE);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] SITES_CNT = CNT_W'(SITES);

  // sequencer states
  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DEC    = 4'd2;
  localparam logic [3:0] ST_L_RD   = 4'd3;
  localparam logic [3:0] ST_L_UPD  = 4'd4;
  localparam logic [3:0] ST_L_INC  = 4'd5;
  localparam logic [3:0] ST_S_RDH  = 4'd6;
  localparam logic [3:0] ST_S_RDN  = 4'd7;
  localparam logic [3:0] ST_S_EVAL = 4'd8;
  localparam logic [3:0] ST_S_W0   = 4'd9;
  localparam logic [3:0] ST_S_W1   = 4'd10;
  localparam logic [3:0] ST_M_RUN  = 4'd11;
  localparam logic [3:0] ST_M_TAIL = 4'd12;
  localparam logic [3:0] ST_FIN    = 4'd13;

  logic [3:0] state_q, state_d;

  // control registers
  logic [AW-1:0]     sweep_q;
  logic              pend_q;
  logic              out_valid_q;
  logic [RATE_W-1:0] switch_rate_q;
  logic [CNT_W-1:0]  count_q [4];

  // item fields and working registers
  logic [MODE_W-1:0]  mode_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic [SP_W-1:0]    sp_q;
  logic [DIR_W-1:0]   dir_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [AW-1:0]      here_q, there_q;
  logic [CUR_W-1:0]   s_q, n_q;
  logic [SP_W-1:0]    rel_q;
  logic               swap_q;
  logic [CNT_W-1:0]   m_ac_q, i_ac_q, c_ac_q, m_bd_q, i_bd_q, c_bd_q;
  result_t            res_q;

  // grid memory port
  logic [AW-1:0]    rd_addr, wr_addr;
  grid_wr_t         gw;
  logic [CUR_W-1:0] rd_cur;
  logic [SP_W-1:0]  rd_ini;

  // shared count unit: one +/-1 on one selected species count
  logic             cnt_en, cnt_up;
  logic [SP_W-1:0]  cnt_sel;
  logic [CNT_W-1:0] cnt_next;

  logic             in_acc, fin_go, in_range;
  logic [CW-1:0]    col_c, row_c, col_n, row_n;

  assign in_acc   = in_i.valid && in_i.ready;
  assign fin_go   = !out_valid_q || out_o.ready;
  assign in_range = (XW'(col_q) < SIDE_X) && (XW'(row_q) < SIDE_X);
  assign cnt_next = cnt_up ? count_q[cnt_sel] + CNT_ONE : count_q[cnt_sel] - CNT_ONE;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // wrapped neighbour coordinates
  always_comb begin
    col_c = CW'(col_q);
    row_c = CW'(row_q);
    col_n = col_c;
    row_n = row_c;
    unique case (dir_q)
      DIR_COL_UP: col_n = (col_c == SIDE_M1) ? '0 : col_c + CRD_ONE;
      DIR_ROW_UP: row_n = (row_c == SIDE_M1) ? '0 : row_c + CRD_ONE;
      DIR_COL_DN: col_n = (col_c == '0) ? SIDE_M1 : col_c - CRD_ONE;
      DIR_ROW_DN: row_n = (row_c == '0) ? SIDE_M1 : row_c - CRD_ONE;
      default:    col_n = col_c;
    endcase
  end

  // sequencer: picks memory addresses, writes and the count operation
  always_comb begin
    state_d = state_q;
    rd_addr = here_q;
    wr_addr = here_q;
    gw      = '0;
    cnt_en  = 1'b0;
    cnt_up  = 1'b1;
    cnt_sel = sp_q;
    unique case (state_q)
      ST_CLR: begin
        // mark every site unwritten
        wr_addr   = sweep_q;
        gw.cur_we = 1'b1;
        if (sweep_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        unique case (mode_q)
          MODE_LOAD:    state_d = in_range ? ST_L_RD : ST_FIN;
          MODE_STEP:    state_d = in_range ? ST_S_RDH : ST_FIN;
          MODE_MEASURE: state_d = ST_M_RUN;
          default:      state_d = ST_FIN;
        endcase
      end
      ST_L_RD: begin
        rd_addr = here_q;
        state_d = ST_L_UPD;
      end
      ST_L_UPD: begin
        // uncount the old species of a reloaded site and store the new one
        gw.cur_we   = 1'b1;
        gw.ini_we   = 1'b1;
        gw.cur_data = {1'b1, sp_q};
        gw.ini_data = sp_q;
        cnt_en      = rd_cur[WR_BIT];
        cnt_up      = 1'b0;
        cnt_sel     = rd_cur[SP_W-1:0];
        state_d     = ST_L_INC;
      end
      ST_L_INC: begin
        cnt_en  = 1'b1;
        cnt_sel = sp_q;
        state_d = ST_FIN;
      end
      ST_S_RDH: begin
        rd_addr = here_q;
        state_d = ST_S_RDN;
      end
      ST_S_RDN: begin
        rd_addr = there_q;
        state_d = ST_S_EVAL;
      end
      ST_S_EVAL: begin
        state_d = ST_S_W0;
      end
      ST_S_W0: begin
        unique case (rel_q)
          REL_PREY: begin
            wr_addr     = there_q;
            gw.cur_we   = 1'b1;
            gw.cur_data = {n_q[WR_BIT], s_q[SP_W-1:0]};
            cnt_en      = 1'b1;
            cnt_sel     = s_q[SP_W-1:0];
          end
          REL_PRED: begin
            wr_addr     = here_q;
            gw.cur_we   = 1'b1;
            gw.cur_data = {s_q[WR_BIT], n_q[SP_W-1:0]};
            cnt_en      = 1'b1;
            cnt_sel     = n_q[SP_W-1:0];
          end
          REL_NEUTRAL: begin
            wr_addr     = here_q;
            gw.cur_we   = swap_q;
            gw.cur_data = {s_q[WR_BIT], n_q[SP_W-1:0]};
          end
          default: cnt_en = 1'b0;
        endcase
        state_d = ST_S_W1;
      end
      ST_S_W1: begin
        unique case (rel_q)
          REL_PREY: begin
            cnt_en  = 1'b1;
            cnt_up  = 1'b0;
            cnt_sel = n_q[SP_W-1:0];
          end
          REL_PRED: begin
            cnt_en  = 1'b1;
            cnt_up  = 1'b0;
            cnt_sel = s_q[SP_W-1:0];
          end
          REL_NEUTRAL: begin
            wr_addr     = there_q;
            gw.cur_we   = swap_q;
            gw.cur_data = {n_q[WR_BIT], s_q[SP_W-1:0]};
          end
          default: cnt_en = 1'b0;
        endcase
        state_d = ST_FIN;
      end
      ST_M_RUN: begin
        rd_addr = sweep_q;
        if (sweep_q == LAST_ADDR) begin
          state_d = ST_M_TAIL;
        end
      end
      ST_M_TAIL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ccls_grid #(
    .SIDE (SIDE)
  ) u_grid (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_i      (gw),
    .rd_cur_o  (rd_cur),
    .rd_ini_o  (rd_ini)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      sweep_q       <= '0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      switch_rate_q <= RATE_RESET;
      for (int i = 0; i < 4; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == ST_M_RUN);
      if (cfg_i.valid) begin
        switch_rate_q <= cfg_i.switch_rate;
      end
      if (cnt_en) begin
        count_q[cnt_sel] <= cnt_next;
      end
      // advance the sweep in the clearing pass and the measure pass
      if (in_acc) begin
        sweep_q <= '0;
      end else if (state_q == ST_CLR || state_q == ST_M_RUN) begin
        sweep_q <= sweep_q + AW'(1);
      end
      if (state_q == ST_FIN && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item fields, working values and the held result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      col_q  <= in_i.col;
      row_q  <= in_i.row;
      sp_q   <= in_i.species;
      dir_q  <= in_i.direction;
      frac_q <= in_i.rand_frac;
      m_ac_q <= '0;
      i_ac_q <= '0;
      c_ac_q <= '0;
      m_bd_q <= '0;
      i_bd_q <= '0;
      c_bd_q <= '0;
    end
    if (state_q == ST_DEC) begin
      here_q  <= AW'(col_c) * SIDE_A + AW'(row_c);
      there_q <= AW'(col_n) * SIDE_A + AW'(row_n);
    end
    if (state_q == ST_S_RDN) begin
      s_q <= rd_cur;
    end
    if (state_q == ST_S_EVAL) begin
      n_q    <= rd_cur;
      rel_q  <= rd_cur[SP_W-1:0] - s_q[SP_W-1:0];
      swap_q <= ({1'b0, frac_q} <= switch_rate_q);
    end
    // tally one site per cycle, in the cycle after its read address is given
    if (pend_q) begin
      if (rd_cur[0] == rd_ini[0]) begin
        if (rd_cur[0]) m_bd_q <= m_bd_q + CNT_ONE;
        else           m_ac_q <= m_ac_q + CNT_ONE;
      end
      if (rd_ini[0]) i_bd_q <= i_bd_q + CNT_ONE;
      else           i_ac_q <= i_ac_q + CNT_ONE;
      if (rd_cur[0]) c_bd_q <= c_bd_q + CNT_ONE;
      else           c_ac_q <= c_ac_q + CNT_ONE;
    end
    if (state_q == ST_FIN && fin_go) begin
      res_q.count_a    <= count_q[0];
      res_q.count_b    <= count_q[1];
      res_q.count_c    <= count_q[2];
      res_q.count_d    <= count_q[3];
      res_q.match_ac   <= m_ac_q;
      res_q.initial_ac <= i_ac_q;
      res_q.now_ac     <= c_ac_q;
      res_q.match_bd   <= m_bd_q;
      res_q.initial_bd <= i_bd_q;
      res_q.now_bd     <= c_bd_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.count_a    = res_q.count_a;
  assign out_o.count_b    = res_q.count_b;
  assign out_o.count_c    = res_q.count_c;
  assign out_o.count_d    = res_q.count_d;
  assign out_o.match_ac   = res_q.match_ac;
  assign out_o.initial_ac = res_q.initial_ac;
  assign out_o.now_ac     = res_q.now_ac;
  assign out_o.match_bd   = res_q.match_bd;
  assign out_o.initial_bd = res_q.initial_bd;
  assign out_o.now_bd     = res_q.now_bd;

  // every accepted item is decoded in the following cycle
  `CCLS_ASSERT_NEXT(a_accept_decodes, in_acc, state_q == ST_DEC, "item not decoded")

  // a finished sweep counts every site once in each pair split
  `CCLS_ASSERT_SAME(a_sweep_covers, state_q == ST_FIN && mode_q == MODE_MEASURE, (CNT_W'(i_ac_q + i_bd_q) == SITES_CNT) && (CNT_W'(c_ac_q + c_bd_q) == SITES_CNT), "sweep tallies miss sites")

  // an item writes only its own site or the chosen neighbour
  `CCLS_ASSERT_SAME(a_write_target, gw.cur_we && state_q != ST_CLR, wr_addr == here_q || wr_addr == there_q, "grid write to a foreign site")

endmodule
